// ===== src/gfvma_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the vector multiply-add block.
`default_nettype none

package gfvma_pkg;

  // Lane geometry: eight byte lanes in a 64-bit word, LANES of them active
  localparam int unsigned WordLanes = 8;
  localparam int unsigned LANES     = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = WordLanes * ByteW;
  localparam int unsigned CountW    = 4;
  localparam int unsigned HalfBits  = ByteW / 2;

  // Reduction polynomial x^8 + x^4 + x^3 + x^2 + 1, low eight bits
  localparam logic [ByteW-1:0] GfPolyLow = 8'h1D;

  // Operation kinds
  localparam logic KindMulAdd = 1'b0;
  localparam logic KindScale  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [WordW-1:0]  dest_word;
    logic [WordW-1:0]  src_word;
    logic [CountW-1:0] byte_count;
    logic              last_word;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic             result_last;
  } out_item_t;

  // Coefficient times x^i, for i = 0..7
  typedef logic [ByteW-1:0][ByteW-1:0] coef_pow_t;

  // Multiply by x modulo the reduction polynomial
  function automatic logic [ByteW-1:0] gf_xtime(input logic [ByteW-1:0] a);
    logic [ByteW-1:0] sh;
    sh = {a[ByteW-2:0], 1'b0};
    return a[ByteW-1] ? (sh ^ GfPolyLow) : sh;
  endfunction

endpackage

`default_nettype wire

// ===== src/gf256_vector_multiply_add.sv =====
// Top level: three-stage pipelined GF(2^8) multiply-add / scale over eight byte lanes.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o    | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i  | out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i, no handshake     | cfg_data_i (coefficient)
//
// One transaction is accepted per cycle while in_stall_o is low; each result passes
// through the three register stages (operand select, low multiplier nibble, high
// multiplier nibble with add and output register) before it is offered on the output.
// Reset clears all stage valid bits and the coefficient (to zero).
// A stall holds only the stages that are full behind it; bubbles still collapse.
`default_nettype none

module gf256_vector_multiply_add (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire gfvma_pkg::in_item_t   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output gfvma_pkg::out_item_t       out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [7:0]            cfg_data_i
);

  import gfvma_pkg::*;

  // Coefficient powers, refreshed on each configuration write
  coef_pow_t pow_q, pow_d;

  // Stage 1: masked multiplier operand and addend
  logic             s1_valid_q;
  logic [WordW-1:0] s1_oper_q, s1_oper_d;
  logic [WordW-1:0] s1_add_q, s1_add_d;
  logic             s1_last_q;

  // Stage 2: partial product over the low multiplier nibble
  logic             s2_valid_q;
  logic [WordW-1:0] s2_acc_q, s2_acc_d;
  logic [WordW-1:0] s2_oper_q;
  logic [WordW-1:0] s2_add_q;
  logic             s2_last_q;

  // Stage 3: output register
  logic             s3_valid_q;
  out_item_t        s3_data_q, s3_data_d;

  logic s1_en, s2_en, s3_en;

  // Advance each stage when it is empty or the one after it moves
  assign s3_en      = !s3_valid_q || !out_stall_i;
  assign s2_en      = !s2_valid_q || s3_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  // Build the table of coefficient times x^i
  always_comb begin
    pow_d[0] = cfg_data_i;
    for (int i = 1; i < ByteW; i++) begin
      pow_d[i] = gf_xtime(pow_d[i-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow_q <= '0;
    end else if (cfg_we_i) begin
      pow_q <= pow_d;
    end
  end

  // Pick the operand per kind and zero lanes beyond the valid count
  always_comb begin
    for (int l = 0; l < WordLanes; l++) begin
      if ((l < LANES) && (CountW'(l) < in_data_i.byte_count)) begin
        if (in_data_i.kind == KindScale) begin
          s1_oper_d[l*ByteW +: ByteW] = in_data_i.dest_word[l*ByteW +: ByteW];
          s1_add_d[l*ByteW +: ByteW]  = '0;
        end else begin
          s1_oper_d[l*ByteW +: ByteW] = in_data_i.src_word[l*ByteW +: ByteW];
          s1_add_d[l*ByteW +: ByteW]  = in_data_i.dest_word[l*ByteW +: ByteW];
        end
      end else begin
        s1_oper_d[l*ByteW +: ByteW] = '0;
        s1_add_d[l*ByteW +: ByteW]  = '0;
      end
    end
  end

  // Accumulate the low multiplier nibble per lane
  always_comb begin
    for (int l = 0; l < WordLanes; l++) begin
      s2_acc_d[l*ByteW +: ByteW] = '0;
      for (int i = 0; i < HalfBits; i++) begin
        if (s1_oper_q[l*ByteW + i]) begin
          s2_acc_d[l*ByteW +: ByteW] = s2_acc_d[l*ByteW +: ByteW] ^ pow_q[i];
        end
      end
    end
  end

  // Finish with the high nibble and fold in the addend
  always_comb begin
    for (int l = 0; l < WordLanes; l++) begin
      s3_data_d.result_word[l*ByteW +: ByteW] =
        s2_acc_q[l*ByteW +: ByteW] ^ s2_add_q[l*ByteW +: ByteW];
      for (int i = HalfBits; i < ByteW; i++) begin
        if (s2_oper_q[l*ByteW + i]) begin
          s3_data_d.result_word[l*ByteW +: ByteW] =
            s3_data_d.result_word[l*ByteW +: ByteW] ^ pow_q[i];
        end
      end
    end
    s3_data_d.result_last = s2_last_q;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Payload registers, held while a stage is stalled
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_oper_q <= s1_oper_d;
      s1_add_q  <= s1_add_d;
      s1_last_q <= in_data_i.last_word;
    end
    if (s2_en) begin
      s2_acc_q  <= s2_acc_d;
      s2_oper_q <= s1_oper_q;
      s2_add_q  <= s1_add_q;
      s2_last_q <= s1_last_q;
    end
    if (s3_en) begin
      s3_data_q <= s3_data_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = s3_data_q;

endmodule

`default_nettype wire
